// ===== hdl/pid_step_size_controller_top_macros.svh =====
// Assertion macros used by the step size controller RTL.
`ifndef PID_STEP_SIZE_CONTROLLER_TOP_MACROS_SVH
`define PID_STEP_SIZE_CONTROLLER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSSC_ASSERT_NOW(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pssc assertion failed");
`define PSSC_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pssc assertion failed");
`else
`define PSSC_ASSERT_NOW(name, clk, rst_n, cond, prop)
`define PSSC_ASSERT_NEXT(name, clk, rst_n, cond, prop)
`endif
`endif

// ===== hdl/pssc_pkg.sv =====
// Shared constants, tables and types of the step size controller.
`default_nettype none
package pssc_pkg;

    localparam int LOG_N = 64;
    localparam int LOG_BITS = $clog2(LOG_N);

    localparam logic signed [15:0] KP = 16'sd4915;
    localparam logic signed [15:0] KI = 16'sd11469;
    localparam logic signed [15:0] KD = 16'sd655;

    localparam logic [31:0] TOL_RESET = 32'd1677722;
    localparam logic [7:0] TARGET_RESET = 8'd8;
    localparam logic SCALING_RESET = 1'b1;
    localparam logic [55:0] CLIP_CAP = '1;

    typedef enum logic [1:0] {
        REG_TOLERANCE = 2'd0,
        REG_TARGET    = 2'd1,
        REG_SCALING   = 2'd2
    } reg_idx_t;

    typedef logic [17:0] tab_t [0:LOG_N];

    typedef struct packed {
        logic       accept;
        logic       log_en;
        logic [1:0] step_sel;
        logic       acc_clr;
        logic       acc_en;
        logic       exp_en;
        logic       pmul_en;
        logic       shift_en;
        logic       div_start;
        logic       div_src;
        logic       r_from_div;
        logic       smul_en;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic tol_now;
        logic scale_needed;
        logic div_done;
    } sts_t;

    function automatic logic [63:0] isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v = v_in;
        res = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2(1+i/N) in Q0.16 by repeated squaring.
    function automatic tab_t build_log_tab();
        tab_t t;
        logic [63:0] y;
        logic [63:0] r;
        for (int i = 0; i < LOG_N; i++)
        begin
            y = (64'd1 << 30) + ((64'(i) << 30) / LOG_N);
            r = '0;
            for (int k = 0; k < 24; k++)
            begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= (64'd1 << 31))
                begin
                    y = y >> 1;
                    r = r | 64'd1;
                end
            end
            t[i] = 18'((r + 64'd128) >> 8);
        end
        t[LOG_N] = 18'd65536;
        return t;
    endfunction

    // 2^(i/N) in Q1.16 from a chain of square roots of two.
    function automatic tab_t build_exp_tab();
        tab_t t;
        logic [63:0] roots [0:23];
        logic [63:0] c;
        logic [63:0] y;
        logic [63:0] x24;
        c = 64'd1 << 31;
        for (int k = 0; k < 24; k++)
        begin
            c = isqrt(c << 30);
            roots[k] = c;
        end
        for (int i = 0; i < LOG_N; i++)
        begin
            x24 = (64'(i) << 24) / LOG_N;
            y = 64'd1 << 30;
            for (int k = 0; k < 24; k++)
            begin
                if (x24[23 - k])
                begin
                    y = (y * roots[k]) >> 30;
                end
            end
            t[i] = 18'((y + 64'd8192) >> 14);
        end
        t[LOG_N] = 18'd131072;
        return t;
    endfunction

    localparam tab_t LOG_TAB = build_log_tab();
    localparam tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

// ===== hdl/pssc_div.sv =====
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
`default_nettype none
module pssc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        trial = {rem_reg[31:0], dvd_reg[63]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (busy_reg)
        begin
            // The quotient bits shift in behind the dividend bits.
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                dvd_next = {dvd_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                dvd_next = {dvd_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

// ===== hdl/pssc_datapath.sv =====
// Datapath: history, log2 unit, exponent, multipliers, divider and result.
`default_nettype none
module pssc_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pssc_pkg::cmd_t cmd,
    output pssc_pkg::sts_t      sts,
    input  wire logic [31:0]    step_size,
    input  wire logic [31:0]    error_value,
    input  wire logic [7:0]     iteration_count,
    input  wire logic [31:0]    tolerance,
    input  wire logic [7:0]     iteration_target,
    input  wire logic           iteration_scaling_on,
    input  wire logic           tol_wr,
    input  wire logic [31:0]    tol_wdata,
    output logic [31:0]         new_step_size,
    output logic                used_tolerance_branch,
    output logic                saturated
);

    localparam int LB = pssc_pkg::LOG_BITS;

    logic [31:0] hist_reg [0:2];
    logic [31:0] dt_reg;
    logic [31:0] err_reg;
    logic [7:0]  iters_reg;
    logic        tb_reg;
    logic signed [23:0] l_reg [0:3];
    logic signed [41:0] s_reg;
    logic [17:0] m_reg;
    logic signed [9:0] xi_reg;
    logic [63:0] prod_reg;
    logic [55:0] r_reg;
    logic [31:0] out_step_reg;
    logic        out_tb_reg;
    logic        out_sat_reg;

    // Log2 of the selected operand, Q6.16.
    logic [31:0] lop;
    logic [31:0] lv;
    logic [4:0]  lp;
    logic [63:0] lsh;
    logic [31:0] lf;
    logic [LB-1:0] lidx;
    logic [15:0] lw;
    logic [17:0] la, lb;
    logic [33:0] lmul;
    logic [16:0] linterp;
    logic signed [23:0] lres;

    always_comb
    begin
        unique case (cmd.step_sel)
            2'd0:    lop = hist_reg[0];
            2'd1:    lop = hist_reg[1];
            2'd2:    lop = hist_reg[2];
            default: lop = tolerance;
        endcase
        lv = (lop == 32'd0) ? 32'd1 : lop;
        lp = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (lv[i])
            begin
                lp = 5'(i);
            end
        end
        lsh = {32'd0, lv} << (6'd32 - {1'b0, lp});
        lf = lsh[31:0];
        lidx = lf[31 -: LB];
        lw = lf[31-LB -: 16];
        la = pssc_pkg::LOG_TAB[lidx];
        lb = pssc_pkg::LOG_TAB[{1'b0, lidx} + (LB+1)'(1)];
        lmul = (lb - la) * lw;
        linterp = 17'(la + 18'(lmul >> 16));
        lres = $signed({3'd0, lp, 16'd0}) - 24'sd1572864 + $signed({7'd0, linterp});
    end

    // One PID term per cycle into the accumulator.
    logic signed [25:0] l0x, l1x, l2x, ltx;
    logic signed [25:0] dsel;
    logic signed [15:0] ksel;
    logic signed [41:0] term;

    always_comb
    begin
        l0x = 26'(l_reg[0]);
        l1x = 26'(l_reg[1]);
        l2x = 26'(l_reg[2]);
        ltx = 26'(l_reg[3]);
        unique case (cmd.step_sel)
            2'd0:
            begin
                dsel = l1x - l2x;
                ksel = pssc_pkg::KP;
            end
            2'd1:
            begin
                dsel = ltx - l2x;
                ksel = pssc_pkg::KI;
            end
            default:
            begin
                dsel = (l0x <<< 1) - l1x - l2x;
                ksel = pssc_pkg::KD;
            end
        endcase
        term = 42'(dsel * ksel);
    end

    // Round to Q16, then split into integer and fraction for 2^x.
    logic signed [41:0] srnd;
    logic [15:0] xf;
    logic [LB-1:0] eidx;
    logic [15:0] ew;
    logic [17:0] ea, eb;
    logic [34:0] emul;
    logic [17:0] mval;

    always_comb
    begin
        srnd = s_reg + 42'sd32768;
        xf = srnd[31:16];
        eidx = xf[15 -: LB];
        ew = {xf[15-LB:0], LB'(0)};
        ea = pssc_pkg::EXP_TAB[eidx];
        eb = pssc_pkg::EXP_TAB[{1'b0, eidx} + (LB+1)'(1)];
        emul = (eb - ea) * ew;
        mval = ea + 18'(emul >> 16);
    end

    // Scale dt*m by 2^(xi-16) and clip.
    logic signed [10:0] sh;
    logic [10:0] nsh;
    logic [63:0] shifted;
    logic [55:0] rpid;

    always_comb
    begin
        sh = {xi_reg[9], xi_reg} - 11'sd16;
        nsh = 11'(-sh);
        shifted = '0;
        if (prod_reg == 64'd0)
        begin
            shifted = '0;
        end
        else if (sh >= 11'sd16)
        begin
            shifted = {8'd0, pssc_pkg::CLIP_CAP};
        end
        else if (sh >= 11'sd0)
        begin
            shifted = prod_reg << sh[3:0];
        end
        else if (sh <= -11'sd64)
        begin
            shifted = '0;
        end
        else
        begin
            shifted = prod_reg >> nsh[5:0];
        end
        rpid = (shifted > {8'd0, pssc_pkg::CLIP_CAP}) ? pssc_pkg::CLIP_CAP : shifted[55:0];
    end

    logic [31:0] mul_b;
    logic        div_done;
    logic [63:0] div_q;

    assign mul_b = tb_reg ? tolerance : {14'd0, m_reg};

    pssc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (cmd.div_src ? {24'd0, iters_reg} : err_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg[0] <= pssc_pkg::TOL_RESET;
            hist_reg[1] <= pssc_pkg::TOL_RESET;
            hist_reg[2] <= pssc_pkg::TOL_RESET;
        end
        else if (tol_wr)
        begin
            hist_reg[0] <= tol_wdata;
            hist_reg[1] <= tol_wdata;
            hist_reg[2] <= tol_wdata;
        end
        else if (cmd.accept)
        begin
            hist_reg[0] <= hist_reg[1];
            hist_reg[1] <= hist_reg[2];
            hist_reg[2] <= error_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dt_reg <= step_size;
            err_reg <= error_value;
            iters_reg <= iteration_count;
            tb_reg <= (error_value > tolerance);
        end
        if (cmd.log_en)
        begin
            l_reg[cmd.step_sel] <= lres;
        end
        if (cmd.acc_clr)
        begin
            s_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            s_reg <= s_reg + term;
        end
        if (cmd.exp_en)
        begin
            m_reg <= mval;
            xi_reg <= srnd[41:32] ;
        end
        if (cmd.pmul_en)
        begin
            prod_reg <= dt_reg * mul_b;
        end
        else if (cmd.smul_en)
        begin
            prod_reg <= r_reg * iteration_target;
        end
        if (cmd.shift_en)
        begin
            r_reg <= rpid;
        end
        else if (cmd.r_from_div)
        begin
            r_reg <= div_q[55:0];
        end
        if (cmd.out_load)
        begin
            out_sat_reg <= |r_reg[55:32];
            out_step_reg <= (|r_reg[55:32]) ? 32'hFFFF_FFFF : r_reg[31:0];
            out_tb_reg <= tb_reg;
        end
    end

    assign sts.tol_now = (error_value > tolerance);
    assign sts.scale_needed = iteration_scaling_on && (iters_reg > iteration_target);
    assign sts.div_done = div_done;

    assign new_step_size = out_step_reg;
    assign used_tolerance_branch = out_tb_reg;
    assign saturated = out_sat_reg;

endmodule
`default_nettype wire

// ===== hdl/pssc_ctrl.sv =====
// Controller state machine that sequences the datapath.
`default_nettype none
`include "pid_step_size_controller_top_macros.svh"
module pssc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output pssc_pkg::cmd_t      cmd,
    input  wire pssc_pkg::sts_t sts
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_TMUL    = 11'b000_0000_0010,
        S_LOG     = 11'b000_0000_0100,
        S_ACC     = 11'b000_0000_1000,
        S_EXP     = 11'b000_0001_0000,
        S_PMUL    = 11'b000_0010_0000,
        S_SHIFT   = 11'b000_0100_0000,
        S_DIVGO   = 11'b000_1000_0000,
        S_DIVWAIT = 11'b001_0000_0000,
        S_SMUL    = 11'b010_0000_0000,
        S_FIN     = 11'b100_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        phase_next = phase_reg;
        cmd = '0;
        cmd.step_sel = cnt_reg;
        cmd.div_src = phase_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.accept = in_valid;
                cnt_next = '0;
                phase_next = 1'b0;
                if (in_valid)
                begin
                    state_next = sts.tol_now ? S_TMUL : S_LOG;
                end
            end
            S_TMUL:
            begin
                cmd.pmul_en = 1'b1;
                state_next = S_DIVGO;
            end
            S_LOG:
            begin
                cmd.log_en = 1'b1;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    cmd.acc_clr = 1'b1;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                cmd.exp_en = 1'b1;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                cmd.pmul_en = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift_en = 1'b1;
                state_next = S_SMUL;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.r_from_div = 1'b1;
                    state_next = phase_reg ? S_FIN : S_SMUL;
                end
            end
            S_SMUL:
            begin
                cmd.smul_en = 1'b1;
                phase_next = 1'b1;
                state_next = sts.scale_needed ? S_DIVGO : S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A division result only arrives while the controller waits for it.
    `PSSC_ASSERT_NOW(a_div_done_wait, clk, rst_n, sts.div_done, state_reg == S_DIVWAIT)
    // A finished word is presented in the cycle after it is loaded.
    `PSSC_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid)
    // An accepted word starts one of the two branches.
    `PSSC_ASSERT_NEXT(a_accept_branch, clk, rst_n, in_valid && in_ready,
        state_reg == S_TMUL || state_reg == S_LOG)

endmodule
`default_nettype wire

// ===== hdl/pid_step_size_controller_top.sv =====
// Top level: APB register file, controller and datapath of the step size controller.
//
// Input words (step_size, error_value, iteration_count) arrive on a valid/ready
// channel; each produces exactly one output word (new_step_size,
// used_tolerance_branch, saturated) on a second valid/ready channel.
// The block works on one word at a time. A word not above tolerance goes through
// the log2 unit, PID accumulator and exp2 stage; a word above tolerance goes
// through the bit-serial divider instead. When iteration scaling applies, the word
// also passes through that divider, a second time for a word above tolerance.
// A finished word sits in an output register, so the next input word is taken
// while it waits; if the receiver stalls, the following word completes and
// waits in the controller until the output register is free.
// Registers on the APB port: tolerance at 0x0 (also reloads the error history),
// iteration_target at 0x4, iteration_scaling_on at 0x8. Write them only when idle.
// Reset sets tolerance to 1677722, target to 8, scaling on, and the history
// to the tolerance; no word is in flight afterwards.
`default_nettype none
module pid_step_size_controller_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] step_size,
    input  wire logic [31:0] error_value,
    input  wire logic [7:0]  iteration_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      new_step_size,
    output logic             used_tolerance_branch,
    output logic             saturated
);

    logic [31:0] tol_reg;
    logic [7:0]  target_reg;
    logic        scaling_reg;
    logic        wr_en;
    logic        tol_wr;
    pssc_pkg::reg_idx_t widx;
    pssc_pkg::cmd_t cmd;
    pssc_pkg::sts_t sts;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign widx = pssc_pkg::reg_idx_t'(paddr[3:2]);
    assign tol_wr = wr_en && (widx == pssc_pkg::REG_TOLERANCE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= pssc_pkg::TOL_RESET;
            target_reg <= pssc_pkg::TARGET_RESET;
            scaling_reg <= pssc_pkg::SCALING_RESET;
        end
        else if (wr_en)
        begin
            unique case (widx)
                pssc_pkg::REG_TOLERANCE: tol_reg <= pwdata;
                pssc_pkg::REG_TARGET:    target_reg <= pwdata[7:0];
                pssc_pkg::REG_SCALING:   scaling_reg <= pwdata[0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            pssc_pkg::REG_TOLERANCE: prdata = tol_reg;
            pssc_pkg::REG_TARGET:    prdata = {24'd0, target_reg};
            pssc_pkg::REG_SCALING:   prdata = {31'd0, scaling_reg};
            default:                 prdata = '0;
        endcase
    end

    pssc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    pssc_datapath u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .sts                   (sts),
        .step_size             (step_size),
        .error_value           (error_value),
        .iteration_count       (iteration_count),
        .tolerance             (tol_reg),
        .iteration_target      (target_reg),
        .iteration_scaling_on  (scaling_reg),
        .tol_wr                (tol_wr),
        .tol_wdata             (pwdata),
        .new_step_size         (new_step_size),
        .used_tolerance_branch (used_tolerance_branch),
        .saturated             (saturated)
    );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the PID step size controller, with a built-in predictor.
`timescale 1ns / 1ps

typedef struct {
    bit [31:0] step;
    bit        tol_branch;
    bit        sat;
} step_result_t;

class step_scoreboard;
    bit [31:0] tol;
    bit [7:0]  target;
    bit        scale_on;
    bit [31:0] hist [3];
    bit [63:0] log_lut [0:64];
    bit [63:0] exp_lut [0:64];
    step_result_t expected_q [$];
    int        errors;

    function new();
        bit [63:0] roots [24];
        bit [63:0] c;
        bit [63:0] y;
        bit [63:0] r;
        bit [63:0] x24;
        c = 64'd1 << 31;
        for (int k = 0; k < 24; k++)
        begin
            c = isqrt(c << 30);
            roots[k] = c;
        end
        for (int i = 0; i < 64; i++)
        begin
            y = (64'd1 << 30) + ((64'(i) << 30) / 64);
            r = 0;
            for (int k = 0; k < 24; k++)
            begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= (64'd1 << 31))
                begin
                    y = y >> 1;
                    r = r | 1;
                end
            end
            log_lut[i] = (r + 128) >> 8;
            x24 = (64'(i) << 24) / 64;
            y = 64'd1 << 30;
            for (int k = 0; k < 24; k++)
            begin
                if (x24[23 - k])
                begin
                    y = (y * roots[k]) >> 30;
                end
            end
            exp_lut[i] = (y + 8192) >> 14;
        end
        log_lut[64] = 65536;
        exp_lut[64] = 131072;
        errors = 0;
        write_reg(pssc_pkg::REG_TOLERANCE, pssc_pkg::TOL_RESET);
        write_reg(pssc_pkg::REG_TARGET, 8);
        write_reg(pssc_pkg::REG_SCALING, 1);
    endfunction

    function bit [63:0] isqrt(bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function void write_reg(pssc_pkg::reg_idx_t idx, bit [31:0] val);
        case (idx)
            pssc_pkg::REG_TOLERANCE:
            begin
                tol = val;
                hist[0] = val;
                hist[1] = val;
                hist[2] = val;
            end
            pssc_pkg::REG_TARGET: target = val[7:0];
            default: scale_on = val[0];
        endcase
    endfunction

    function bit [63:0] lerp(bit is_exp, bit [63:0] idx, bit [63:0] w);
        bit [63:0] a;
        bit [63:0] b;
        a = is_exp ? exp_lut[idx] : log_lut[idx];
        b = is_exp ? exp_lut[idx + 1] : log_lut[idx + 1];
        return (a * (65536 - w) + b * w) >> 16;
    endfunction

    // Q8.24 value to a Q16 log2; zero counts as one LSB.
    function longint log2q(bit [31:0] r);
        int p;
        bit [63:0] f;
        bit [63:0] t;
        if (r == 0)
            r = 1;
        p = 31;
        while (r[p] == 1'b0)
            p--;
        f = ({32'd0, r} << (32 - p)) & 64'hFFFF_FFFF;
        t = f * 64;
        return longint'(p - 24) * 65536 + longint'(lerp(0, t >> 32, (t >> 16) & 64'hFFFF));
    endfunction

    function bit [63:0] pid_step(bit [63:0] dt);
        longint s;
        longint x;
        longint xi;
        longint sh;
        bit [63:0] xf;
        bit [63:0] u;
        bit [63:0] m;
        bit [63:0] prod;
        bit [63:0] r;
        bit [63:0] cap;
        longint l0;
        longint l1;
        longint l2;
        longint lt;
        cap = (64'd1 << 56) - 1;
        l0 = log2q(hist[0]);
        l1 = log2q(hist[1]);
        l2 = log2q(hist[2]);
        lt = log2q(tol);
        s = 4915 * (l1 - l2) + 11469 * (lt - l2) + 655 * (2 * l0 - l1 - l2);
        x = (s + 32768) >>> 16;
        xf = x & 64'hFFFF;
        xi = x >>> 16;
        u = xf * 64;
        m = lerp(1, u >> 16, u & 64'hFFFF);
        prod = dt * m;
        sh = xi - 16;
        if (prod == 0)
            return 0;
        if (sh >= 16)
            return cap;
        if (sh >= 0)
            r = prod << sh;
        else if (sh <= -64)
            r = 0;
        else
            r = prod >> (-sh);
        return (r > cap) ? cap : r;
    endfunction

    function void note_input(bit [31:0] dt, bit [31:0] err, bit [7:0] iters);
        step_result_t e;
        bit [63:0] r;
        hist[0] = hist[1];
        hist[1] = hist[2];
        hist[2] = err;
        e.tol_branch = err > tol;
        if (e.tol_branch)
            r = ({32'd0, dt} * {32'd0, tol}) / {32'd0, err};
        else
            r = pid_step({32'd0, dt});
        if (scale_on && iters > target)
            r = (r * target) / iters;
        e.sat = r > 64'hFFFF_FFFF;
        e.step = e.sat ? 32'hFFFF_FFFF : r[31:0];
        expected_q.insert(expected_q.size(), e);
    endfunction

    function void check_result(bit [31:0] step, bit tb, bit sat);
        step_result_t e;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t unexpected word: step %h branch %b sat %b", $time, step, tb, sat);
            return;
        end
        e = expected_q.pop_front();
        if (e.step !== step || e.tol_branch !== tb || e.sat !== sat)
        begin
            errors++;
            $display("%0t mismatch: expected step %h branch %b sat %b, got %h %b %b",
                     $time, e.step, e.tol_branch, e.sat, step, tb, sat);
        end
    endfunction
endclass

module testbench;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] step_size = '0;
    logic [31:0] error_value = '0;
    logic [7:0]  iteration_count = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] new_step_size;
    logic        used_tolerance_branch;
    logic        saturated;

    step_scoreboard sb = new();
    bit  no_gaps = 1'b0;
    int  words_out = 0;
    longint cycles = 0;

    pid_step_size_controller_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1000000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(new_step_size, used_tolerance_branch, saturated);
            words_out <= words_out + 1;
        end
    end

    // Receiver: random stalls, plus one long hold so the block backs up.
    initial
    begin
        int hold;
        bit held;
        held = 0;
        forever
        begin
            @(negedge clk);
            if (!held && words_out >= 150)
            begin
                held = 1;
                out_ready <= 1'b0;
                hold = 0;
                while (hold < 600)
                begin
                    @(negedge clk);
                    hold++;
                end
            end
            out_ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 24);
        end
    end

    task automatic send_word(bit [31:0] dt, bit [31:0] err, bit [7:0] iters);
        @(negedge clk);
        if (!no_gaps && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        step_size <= dt;
        error_value <= err;
        iteration_count <= iters;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(dt, err, iters);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic reg_write(pssc_pkg::reg_idx_t idx, bit [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_words(int count);
        bit [31:0] dt;
        bit [31:0] err;
        bit [7:0]  iters;
        for (int i = 0; i < count; i++)
        begin
            dt = $urandom >> $urandom_range(0, 31);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: err = (sb.tol >> $urandom_range(0, 10)) ^ ($urandom & 32'hFF);
                4, 5: err = sb.tol + $urandom_range(0, 1000);
                6: err = $urandom_range(0, 3);
                default: err = $urandom;
            endcase
            if ($urandom_range(0, 1))
                iters = 8'($urandom_range(0, 255));
            else
                iters = 8'(sb.target + $urandom_range(0, 6) - 3);
            send_word(dt, err, iters);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, boundary around the tolerance, zero errors.
        send_word(32'd0, 32'd0, 8'd0);
        send_word(32'hFFFF_FFFF, 32'd0, 8'd0);
        send_word(32'hFFFF_FFFF, 32'd0, 8'd255);
        send_word(32'hFFFF_FFFF, 32'd0, 8'd9);
        send_word(32'd25600, pssc_pkg::TOL_RESET, 8'd8);
        send_word(32'd25600, pssc_pkg::TOL_RESET + 1, 8'd8);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1);
        send_word(32'd1, 32'hFFFF_FFFF, 8'd255);
        send_word(32'd1, 32'd1, 8'd0);
        send_word(32'h8000_0000, pssc_pkg::TOL_RESET >> 1, 8'd16);
        send_word(32'h0001_0000, pssc_pkg::TOL_RESET >> 4, 8'd7);
        send_word(32'h0001_0000, 32'd100, 8'd200);
        wait_idle();
        reg_write(pssc_pkg::REG_SCALING, 0);
        send_word(32'hFFFF_FFFF, 32'd0, 8'd255);
        send_word(32'h1234_5678, 32'hFFFF_FFFF, 8'd255);
        wait_idle();
        // Zero target drives any nonzero count to a zero step.
        reg_write(pssc_pkg::REG_TARGET, 0);
        reg_write(pssc_pkg::REG_SCALING, 1);
        send_word(32'h1234_5678, 32'd1000, 8'd1);
        send_word(32'h1234_5678, 32'hFFFF_FFFF, 8'd0);
        wait_idle();
        // A zero tolerance sends every nonzero error to the division path.
        reg_write(pssc_pkg::REG_TOLERANCE, 0);
        send_word(32'h0000_1000, 32'd0, 8'd3);
        send_word(32'h0000_1000, 32'd1, 8'd3);
        random_words(40);
        wait_idle();

        reg_write(pssc_pkg::REG_TOLERANCE, pssc_pkg::TOL_RESET);
        reg_write(pssc_pkg::REG_TARGET, 8);
        random_words(200);
        wait_idle();
        reg_write(pssc_pkg::REG_TOLERANCE, 1);
        reg_write(pssc_pkg::REG_TARGET, 1);
        random_words(120);
        wait_idle();
        reg_write(pssc_pkg::REG_TOLERANCE, 32'hFFFF_FFFF);
        reg_write(pssc_pkg::REG_TARGET, 255);
        no_gaps = 1'b1;
        random_words(150);
        no_gaps = 1'b0;
        wait_idle();
        reg_write(pssc_pkg::REG_TOLERANCE, $urandom);
        reg_write(pssc_pkg::REG_TARGET, $urandom_range(1, 255));
        reg_write(pssc_pkg::REG_SCALING, 0);
        random_words(140);
        wait_idle();
        reg_write(pssc_pkg::REG_TOLERANCE, $urandom >> $urandom_range(0, 20));
        reg_write(pssc_pkg::REG_TARGET, $urandom_range(1, 30));
        reg_write(pssc_pkg::REG_SCALING, 1);
        random_words(280);
        wait_idle();
        repeat (200) @(negedge clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
